// File: hw/rtl/irwl_pkg.sv
// Shared types, widths and constants for the image range window/level block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package irwl_pkg;

	localparam int CHAN_W         = 16;
	localparam int NORM_FRAC_BITS = 16;
	localparam int NORM_W         = NORM_FRAC_BITS + 1;
	localparam int PROD_W         = CHAN_W + NORM_W;
	localparam int NUM_LANES      = 3;
	localparam int CFG_IDX_W      = 2;
	localparam int IN_DATA_W      = ((NUM_LANES * CHAN_W + 7) / 8) * 8;
	localparam int OUT_DATA_W     = ((6 * CHAN_W + 7) / 8) * 8;

	localparam logic [NORM_W-1:0] NORM_ONE   = NORM_W'(1) << NORM_FRAC_BITS;
	localparam logic [NORM_W-1:0] NORM_LOW   = NORM_W'((64'd1 << NORM_FRAC_BITS) / 64'd100);
	localparam logic [NORM_W-1:0] NORM_HALF  = NORM_W'(1) << (NORM_FRAC_BITS - 1);
	localparam logic [CHAN_W-1:0] CHAN_MAX   = '1;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [NORM_W-1:0] norm_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_NORM = 2'd0,
		REG_LEVEL_NORM  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		chan_t lo;
		chan_t hi;
	} range_t;

	typedef struct packed {
		logic   valid;
		range_t rng;
	} range_push_t;

	typedef struct packed {
		chan_t range_min;
		chan_t range_max;
		chan_t level_value;
		chan_t window_value;
		chan_t display_low;
		chan_t display_high;
	} result_t;

	function automatic norm_t clamp_norm(input norm_t v);
		norm_t r;
		if (v < NORM_LOW) begin
			r = NORM_LOW;
		end else if (v > NORM_ONE) begin
			r = NORM_ONE;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/irwl_lane.sv
// One channel lane: folds a single sample into the running range.
// Depends on irwl_pkg.
`default_nettype none

module irwl_lane import irwl_pkg::*; (
	input  chan_t  sample,
	input  range_t run,
	output range_t cand
);

	always_comb begin
		cand.lo = (sample < run.lo) ? sample : run.lo;
		cand.hi = (sample > run.hi) ? sample : run.hi;
	end

endmodule

`default_nettype wire

// File: hw/rtl/irwl_range_acc.sv
// Running min/max over all channels: three lanes and a merging stage.
// Depends on irwl_pkg and irwl_lane.
`default_nettype none

module irwl_range_acc import irwl_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          last,
	input  logic [NUM_LANES*CHAN_W-1:0]   samples,
	output range_push_t                   push
);

	range_t run_q;
	range_t cand [NUM_LANES];
	range_t merged;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		irwl_lane u_lane (
			.sample (samples[g*CHAN_W +: CHAN_W]),
			.run    (run_q),
			.cand   (cand[g])
		);
	end

	always_comb begin
		merged = cand[0];
		for (int i = 1; i < NUM_LANES; i++) begin
			if (cand[i].lo < merged.lo) begin
				merged.lo = cand[i].lo;
			end
			if (cand[i].hi > merged.hi) begin
				merged.hi = cand[i].hi;
			end
		end
	end

	assign push.valid = fire && last;
	assign push.rng   = merged;

	// restart the range after the last pixel of an image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q.lo <= CHAN_MAX;
			run_q.hi <= '0;
		end else if (fire) begin
			if (last) begin
				run_q.lo <= CHAN_MAX;
				run_q.hi <= '0;
			end else begin
				run_q <= merged;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/irwl_wl_calc.sv
// Window/level pipeline: span, scaling products, clamps, display bounds.
// Depends on irwl_pkg.
`default_nettype none

module irwl_wl_calc import irwl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  range_push_t push,
	output logic        push_ready,
	input  norm_t       window_norm,
	input  norm_t       level_norm,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	logic   v_s1, v_s2, v_s3, v_s4, vo_q;
	logic   rdy1, rdy2, rdy3, rdy4, rdyo;
	range_t rng_s1, rng_s2, rng_s3, rng_s4;
	chan_t  span_s2;
	chan_t  loff_s3, wraw_s3;
	chan_t  level_s4, window_s4;
	result_t res_q;

	logic [PROD_W-1:0] prod_l, prod_w;
	logic [CHAN_W:0]   level_sum, high_sum;
	chan_t             level_c, window_c, half, diff, dlow_c, dhigh_c;

	assign rdyo       = !vo_q || res_ready;
	assign rdy4       = !v_s4 || rdyo;
	assign rdy3       = !v_s3 || rdy4;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign push_ready = rdy1;

	always_comb begin
		prod_l    = PROD_W'(span_s2) * PROD_W'(level_norm);
		prod_w    = PROD_W'(span_s2) * PROD_W'(window_norm);

		level_sum = {1'b0, rng_s3.lo} + {1'b0, loff_s3};
		level_c   = (level_sum > {1'b0, rng_s3.hi}) ? rng_s3.hi : level_sum[CHAN_W-1:0];
		if (wraw_s3 < rng_s3.lo) begin
			window_c = rng_s3.lo;
		end else if (wraw_s3 > rng_s3.hi) begin
			window_c = rng_s3.hi;
		end else begin
			window_c = wraw_s3;
		end

		half     = window_s4 >> 1;
		diff     = level_s4 - rng_s4.lo;
		dlow_c   = (half > diff) ? rng_s4.lo : (level_s4 - half);
		high_sum = {1'b0, level_s4} + {1'b0, half};
		dhigh_c  = (high_sum > {1'b0, rng_s4.hi}) ? rng_s4.hi : high_sum[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= push.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdyo) begin
				vo_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && push.valid) begin
			rng_s1 <= push.rng;
		end
		if (rdy2 && v_s1) begin
			rng_s2  <= rng_s1;
			span_s2 <= rng_s1.hi - rng_s1.lo;
		end
		if (rdy3 && v_s2) begin
			rng_s3  <= rng_s2;
			loff_s3 <= prod_l[NORM_FRAC_BITS +: CHAN_W];
			wraw_s3 <= prod_w[NORM_FRAC_BITS +: CHAN_W];
		end
		if (rdy4 && v_s3) begin
			rng_s4    <= rng_s3;
			level_s4  <= level_c;
			window_s4 <= window_c;
		end
		if (rdyo && v_s4) begin
			res_q.range_min    <= rng_s4.lo;
			res_q.range_max    <= rng_s4.hi;
			res_q.level_value  <= level_s4;
			res_q.window_value <= window_s4;
			res_q.display_low  <= dlow_c;
			res_q.display_high <= dhigh_c;
		end
	end

	assign res_valid = vo_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/image_range_window_level.sv
// Top level of the image range window/level block.
// Depends on irwl_pkg, irwl_range_acc and irwl_wl_calc.
//
// Takes one pixel per clock while ready is high (three 16-bit samples, tlast on
// the final pixel of an image) and keeps the min and max over all samples in one
// register pair updated by three compare lanes. On the last pixel the range
// enters a five-register pipeline (span, two 16x17 products, clamps, display
// bounds), and one result item leaves m_axis from its last register. Input ready
// drops only when that pipeline is full and the output is stalled. Window and
// level are unsigned Q1.16 fractions, clamped to 0.01..1.0 when written, and must
// be written only while no image result is in flight; the block does not check.
`default_nettype none

module image_range_window_level import irwl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // chan_red, chan_green, chan_blue
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// range_min, range_max, level_value, window_value, display_low, display_high
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [NORM_W-1:0]      cfg_data
);

	norm_t       window_norm_q, level_norm_q;
	range_push_t push;
	logic        push_ready;
	logic        in_fire;
	result_t     res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = push_ready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_norm_q <= NORM_ONE;
			level_norm_q  <= NORM_HALF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_NORM: window_norm_q <= clamp_norm(cfg_data);
				REG_LEVEL_NORM:  level_norm_q  <= clamp_norm(cfg_data);
				default: ;
			endcase
		end
	end

	irwl_range_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (in_fire),
		.last    (s_axis_tlast),
		.samples (s_axis_tdata[NUM_LANES*CHAN_W-1:0]),
		.push    (push)
	);

	irwl_wl_calc u_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_ready  (push_ready),
		.window_norm (window_norm_q),
		.level_norm  (level_norm_q),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res         (res)
	);

	assign m_axis_tdata = {res.display_high, res.display_low, res.window_value,
	                       res.level_value, res.range_max, res.range_min};

`ifndef NO_ASSERTIONS
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.range_min <= res.range_max)
		else $error("result range min above max");

	a_level_in_display: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.display_low <= res.level_value &&
		                   res.level_value <= res.display_high))
		else $error("level outside display bounds");

	a_display_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.range_min <= res.display_low &&
		                   res.display_high <= res.range_max))
		else $error("display bounds outside image range");
`endif

endmodule

`default_nettype wire

// File: sim/irwl_wl_tracker.sv
// Predicts and checks result items of image_range_window_level from the pixel, register
// and result channels it watches. Depends on irwl_pkg; counts every mismatch it finds.
`timescale 1ns / 100ps

module irwl_wl_tracker import irwl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // chan_red, chan_green, chan_blue
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// range_min, range_max, level_value, window_value, display_low, display_high
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [NORM_W-1:0]     cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef logic [5:0][CHAN_W-1:0] wl_fields_t;

	string field_label [6] = '{"range_min", "range_max", "level_value",
		"window_value", "display_low", "display_high"};

	wl_fields_t wl_due [$];
	norm_t      window_frac;
	norm_t      level_frac;
	chan_t      seen_min;
	chan_t      seen_max;

	function automatic norm_t bound_norm(input norm_t raw);
		if (raw < NORM_LOW) begin
			return NORM_LOW;
		end
		if (raw > NORM_ONE) begin
			return NORM_ONE;
		end
		return raw;
	endfunction

	function automatic int fit(input int v, input int lo, input int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic wl_fields_t calc_window_level(input chan_t lo, input chan_t hi,
			input norm_t win, input norm_t lvl);
		chan_t             span;
		logic [PROD_W-1:0] lvl_prod;
		logic [PROD_W-1:0] win_prod;
		int                level;
		int                window;
		int                half;
		wl_fields_t        r;
		span     = hi - lo;
		lvl_prod = PROD_W'(span) * PROD_W'(lvl);
		win_prod = PROD_W'(span) * PROD_W'(win);
		level    = fit(int'(lo) + int'(lvl_prod >> NORM_FRAC_BITS), int'(lo), int'(hi));
		window   = fit(int'(win_prod >> NORM_FRAC_BITS), int'(lo), int'(hi));
		half     = window / 2;
		r[0] = lo;
		r[1] = hi;
		r[2] = chan_t'(level);
		r[3] = chan_t'(window);
		r[4] = chan_t'(fit(level - half, int'(lo), int'(hi)));
		r[5] = chan_t'(fit(level + half, int'(lo), int'(hi)));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chan_t      lo;
		chan_t      hi;
		chan_t      s;
		wl_fields_t got;
		wl_fields_t want;
		if (!arst_n) begin
			wl_due.delete();
			window_frac = NORM_ONE;
			level_frac  = NORM_HALF;
			seen_min    = CHAN_MAX;
			seen_max    = '0;
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_NORM: window_frac = bound_norm(cfg_data);
					REG_LEVEL_NORM:  level_frac  = bound_norm(cfg_data);
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				lo = seen_min;
				hi = seen_max;
				for (int k = 0; k < NUM_LANES; k++) begin
					s = s_axis_tdata[k*CHAN_W +: CHAN_W];
					if (s < lo) lo = s;
					if (s > hi) hi = s;
				end
				if (s_axis_tlast) begin
					wl_due.push_back(calc_window_level(lo, hi, window_frac, level_frac));
					seen_min = CHAN_MAX;
					seen_max = '0;
				end else begin
					seen_min = lo;
					seen_max = hi;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[6*CHAN_W-1:0];
				if (wl_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result item with none expected: %h", $realtime, got);
					end
				end else begin
					want = wl_due.pop_front();
					for (int k = 0; k < 6; k++) begin
						if (got[k] !== want[k]) begin
							mismatches++;
							if (mismatches <= 10) begin
								$display("%0t: %s expected %0d, got %0d", $realtime,
									field_label[k], want[k], got[k]);
							end
						end
					end
				end
			end
			outstanding = wl_due.size();
		end
	end

endmodule

// File: sim/image_range_window_level_test.sv
// Stimulus and verdict for image_range_window_level: directed pixels, then register
// settings with random images, idling and output hold-off. Depends on irwl_pkg and irwl_wl_tracker.
`timescale 1ns / 100ps

module image_range_window_level_test;
	import irwl_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [NORM_W-1:0]     cfg_data;
	int                    mismatches;
	int                    outstanding;
	int                    quiet_cycles = 0;
	int                    items_sent = 0;
	int                    hold_asks = 0;
	int                    holds_done = 0;
	logic                  steady = 1'b0;

	image_range_window_level DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	irwl_wl_tracker tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 29);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue,
			input logic last);
		while (!steady && $urandom_range(99) < 29) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {blue, green, red};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NORM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic chan_t pick_sample(input int mode, input chan_t base, input int spread);
		case (mode)
			0: return chan_t'($urandom);
			1: return base + chan_t'($urandom_range(spread));
			2: begin
				case ($urandom_range(2))
					0: return '0;
					1: return CHAN_MAX;
					default: return chan_t'($urandom);
				endcase
			end
			default: return base;
		endcase
	endfunction

	task automatic send_image(input int pixels);
		int    mode;
		int    spread;
		chan_t base;
		mode   = $urandom_range(3);
		spread = $urandom_range(255);
		base   = chan_t'($urandom_range(65535 - spread));
		for (int p = 0; p < pixels; p++) begin
			send_pixel(pick_sample(mode, base, spread), pick_sample(mode, base, spread),
				pick_sample(mode, base, spread), p == pixels - 1);
		end
	endtask

	task automatic run_phase(input logic [NORM_W-1:0] win, input logic [NORM_W-1:0] lvl,
			input int pixel_goal);
		int stop;
		settle();
		write_reg(REG_WINDOW_NORM, win);
		write_reg(REG_LEVEL_NORM, lvl);
		stop = items_sent + pixel_goal;
		while (items_sent < stop) begin
			send_image(($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_WINDOW_NORM;
		cfg_data      = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_pixel('0, '0, '0, 1'b1);
		send_pixel(CHAN_MAX, '0, 16'h8000, 1'b1);
		send_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
		send_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1);
		send_pixel(16'd100, 16'd200, 16'd300, 1'b0);
		send_pixel(16'd50, 16'd60, 16'd70, 1'b0);
		send_pixel(16'd1000, 16'd2, 16'd3, 1'b1);
		send_pixel(16'd40000, 16'd40100, 16'd40050, 1'b1);
		send_pixel(16'hAAAA, 16'h5555, CHAN_MAX, 1'b0);
		send_pixel(16'h5555, 16'hAAAA, '0, 1'b1);
		send_pixel(16'd7, 16'd7, 16'd7, 1'b1);
		send_pixel(16'd1, CHAN_MAX - 16'd1, 16'h1234, 1'b1);
		send_pixel(16'd30000, 16'd20000, 16'd60000, 1'b0);
		send_pixel(16'd20000, 16'd30000, 16'd10000, 1'b1);

		settle();
		write_reg(REG_SPARE_LO, 17'h1FFFF);
		write_reg(REG_SPARE_HI, '0);
		send_pixel(16'd100, 16'd900, 16'd500, 1'b1);

		run_phase(17'd0, 17'd654, 70);
		run_phase(17'h1FFFF, 17'd65537, 70);
		run_phase(NORM_LOW, NORM_ONE, 70);

		steady = 1'b1;
		run_phase(NORM_W'($urandom_range(600, 70000)), NORM_W'($urandom_range(600, 70000)), 70);
		steady = 1'b0;

		run_phase(17'd32768, 17'd16384, 0);
		steady = 1'b1;
		hold_asks++;
		repeat (20) send_image(2);
		steady = 1'b0;
		repeat (15) send_image($urandom_range(1, 5));

		run_phase(NORM_W'($urandom_range(600, 70000)), NORM_W'($urandom_range(600, 70000)), 70);

		settle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
